@@ rtl/pixel_color_grade_assert.svh @@
// Assertion macros for the colour grading pipeline.
`ifndef PIXEL_COLOR_GRADE_ASSERT_SVH
`define PIXEL_COLOR_GRADE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PCG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel_color_grade: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PCG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel_color_grade: next-cycle check failed");

`endif

@@ rtl/pcg_pkg.sv @@
// Types, constants and helper functions of the colour grading pipeline.
package pcg_pkg;

	typedef logic signed [15:0] q12_t;
	typedef logic signed [39:0] wide_t;

	typedef enum logic [2:0] {
		REG_BRIGHTNESS,
		REG_CONTRAST,
		REG_SATURATION,
		REG_HUE,
		REG_TEMPERATURE,
		REG_TINT
	} cfg_reg_t;

	localparam int CFG_WIDE_W   = 15;
	localparam int CFG_NARROW_W = 14;
	localparam int CFG_INDEX_W  = 3;

	localparam logic signed [13:0] THRESH    = 14'sd41;
	localparam int                 LUMA_R    = 1225;
	localparam int                 LUMA_G    = 2404;
	localparam int                 LUMA_B    = 467;
	localparam int                 TENTH     = 410;
	localparam int                 TWENTIETH = 205;

	function automatic wide_t rnd12(input wide_t v);
		rnd12 = (v + 40'sd2048) >>> 12;
	endfunction

	function automatic q12_t sat16(input wide_t v);
		if (v > 40'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -40'sd32768) begin
			sat16 = -16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	function automatic logic [12:0] clamp01(input q12_t v);
		if (v < 16'sd0) begin
			clamp01 = 13'd0;
		end else if (v > 16'sd4096) begin
			clamp01 = 13'd4096;
		end else begin
			clamp01 = v[12:0];
		end
	endfunction

endpackage

@@ rtl/pixel_color_grade.sv @@
// Colour grading pipeline: brightness, contrast, saturation, hue, temperature and tint.
//
// One RGBA pixel enters per beat on the pix channel (pix_valid, pix_stall) and one
// graded pixel leaves per beat on the res channel (res_valid, res_stall).
// The pipeline has fourteen register stages, and one pixel is taken in every
// cycle unless the pipeline holds. The longest path per stage is one multiplier
// of at most about 32 by 32 bits; the hue stage divisions use reciprocal tables
// and multipliers. When res_stall is high while a result is offered, the whole
// pipeline holds and pix_stall is raised in the same cycle; no beat is lost or
// repeated. Empty stages are filled while the result side is not holding a beat.
// Settings are written through the cfg channel, which is always ready; writes
// to an index beyond the register list are ignored. They must only be changed
// while no pixel is in flight.
// Reset clears every stage valid flag and returns all settings to zero, which
// leaves the pixel unchanged apart from rounding.
module pixel_color_grade
	import pcg_pkg::*;
#(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  logic [CHANNEL_BITS-1:0]          red_in,
	input  logic [CHANNEL_BITS-1:0]          green_in,
	input  logic [CHANNEL_BITS-1:0]          blue_in,
	input  logic [CHANNEL_BITS-1:0]          alpha_in,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [CHANNEL_BITS-1:0]          red_out,
	output logic [CHANNEL_BITS-1:0]          green_out,
	output logic [CHANNEL_BITS-1:0]          blue_out,
	output logic [CHANNEL_BITS-1:0]          alpha_out,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [CFG_INDEX_W-1:0]           cfg_index,
	input  logic [CFG_WIDE_W-1:0]            cfg_data
);

	localparam int CB       = CHANNEL_BITS;
	localparam int M        = (1 << CB) - 1;
	localparam int NUM_W    = CB + 13;
	localparam int NSH      = NUM_W + CB;
	localparam int RECIP_W  = NUM_W + 1;
	localparam logic [63:0] RECIP_N = ((64'd1 << NSH) + 64'(M) - 64'd1) / 64'(M);

	// Settings.
	logic signed [CFG_WIDE_W-1:0]   bri_q, con_q, sat_q;
	logic signed [CFG_NARROW_W-1:0] hue_q, tmp_q, tnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bri_q <= '0;
			con_q <= '0;
			sat_q <= '0;
			hue_q <= '0;
			tmp_q <= '0;
			tnt_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BRIGHTNESS:  bri_q <= cfg_data;
				REG_CONTRAST:    con_q <= cfg_data;
				REG_SATURATION:  sat_q <= cfg_data;
				REG_HUE:         hue_q <= cfg_data[CFG_NARROW_W-1:0];
				REG_TEMPERATURE: tmp_q <= cfg_data[CFG_NARROW_W-1:0];
				REG_TINT:        tnt_q <= cfg_data[CFG_NARROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic signed [16:0] k_bri, k_con, k_sat;
	logic               hue_on, tmp_on, tnt_pos, tnt_neg;
	wide_t              t_tmp, t_tnt_rb, t_tnt_g, t_tnt_neg;

	assign k_bri   = 17'sd4096 + 17'(bri_q);
	assign k_con   = 17'sd4096 + 17'(con_q);
	assign k_sat   = 17'sd4096 + 17'(sat_q);
	assign hue_on  = (hue_q > THRESH) || (hue_q < -THRESH);
	assign tmp_on  = (tmp_q > THRESH) || (tmp_q < -THRESH);
	assign tnt_pos = tnt_q > THRESH;
	assign tnt_neg = tnt_q < -THRESH;
	assign t_tmp     = rnd12(40'(tmp_q) * 40'sd410);
	assign t_tnt_rb  = rnd12(40'(tnt_q) * 40'(TENTH));
	assign t_tnt_g   = rnd12(40'(tnt_q) * 40'(TWENTIETH));
	assign t_tnt_neg = t_tnt_rb;

	// Reciprocal tables for the hue stage divisions, and a table mapping 8-bit values back to the Q12 scale.
	logic [28:0] recip_hi_tbl [256];
	logic [31:0] recip6_tbl   [256];
	logic [12:0] back_tbl     [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_tbl
		localparam logic [63:0] DH  = (gi == 0) ? 64'd1 : 64'(gi);
		localparam logic [63:0] D6  = 64'd6 * DH;
		localparam logic [63:0] RH  = ((64'd1 << 28) + DH - 64'd1) / DH;
		localparam logic [63:0] R6  = ((64'd1 << 34) + D6 - 64'd1) / D6;
		localparam logic [63:0] BK  = (64'(gi) * 64'd4096 + 64'd127) / 64'd255;
		assign recip_hi_tbl[gi] = RH[28:0];
		assign recip6_tbl[gi]   = R6[31:0];
		assign back_tbl[gi]     = BK[12:0];
	end

	// Pipeline control.
	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic valid_s8, valid_s9, valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;

	assign adv       = !(valid_s14 && res_stall);
	assign pix_stall = !adv;
	assign res_valid = valid_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else if (adv) begin
			valid_s1  <= pix_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	// Payload stages.
	logic [CB-1:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5, alpha_s6, alpha_s7;
	logic [CB-1:0] alpha_s8, alpha_s9, alpha_s10, alpha_s11, alpha_s12, alpha_s13, alpha_s14;
	logic [12:0]   norm_s1 [3];
	q12_t          ch_s2 [3];
	q12_t          ch_s3 [3];
	q12_t          ch_s4 [3];
	q12_t          gray_s4;
	q12_t          ch_s5 [3];
	q12_t          ch_s6 [3];
	logic [7:0]    c8_s6 [3];
	q12_t          ch_s7 [3];
	logic [7:0]    hi_s7, d_s7;
	logic signed [11:0] n_s7;
	q12_t          ch_s8 [3];
	logic [7:0]    hi_s8;
	logic          dz_s8, neg_s8;
	logic [19:0]   snum_s8;
	logic [22:0]   hnum_s8;
	logic [28:0]   rh_s8;
	logic [31:0]   r6_s8;
	q12_t          ch_s9 [3];
	logic [7:0]    v_s9;
	logic          dz_s9, neg_s9;
	logic [12:0]   s_s9, hmag_s9;
	q12_t          ch_s10 [3];
	logic [7:0]    v_s10, x_s10;
	logic          dz_s10;
	logic [2:0]    sector_s10;
	logic [24:0]   sf_s10, sfc_s10;
	q12_t          ch_s11 [3];
	logic [7:0]    v_s11, x_s11, y_s11, z_s11;
	logic          dz_s11;
	logic [2:0]    sector_s11;
	q12_t          ch_s12 [3];
	q12_t          ch_s13 [3];
	logic [CB-1:0] col_s14 [3];

	// Combinational values per stage.
	logic [NUM_W-1:0]         norm_num [3];
	logic [NUM_W+RECIP_W-1:0] norm_prod [3];
	q12_t                     bri_res [3];
	q12_t                     con_res [3];
	wide_t                    luma_sum;
	q12_t                     sat_res [3];
	logic [7:0]               c8_res [3];
	logic [7:0]               hi_c, lo_c, d_c;
	logic signed [11:0]       n_c;
	logic [10:0]              absn_c;
	logic [48:0]              sprod_c;
	logic [54:0]              hprod_c;
	logic [11:0]              hq_c, hsum_c;
	logic [14:0]              h6_c;
	logic [12:0]              fcomp_c;
	logic [20:0]              xprod_c;
	logic [32:0]              yprod_c, zprod_c;
	logic [7:0]               map_c [3];
	q12_t                     hue_res [3];
	q12_t                     tt_res [3];
	logic [CB+12:0]           out_prod [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			norm_num[i]  = '0;
			norm_prod[i] = '0;
		end
		norm_num[0] = {1'b0, red_in, 12'd0} + NUM_W'(M / 2);
		norm_num[1] = {1'b0, green_in, 12'd0} + NUM_W'(M / 2);
		norm_num[2] = {1'b0, blue_in, 12'd0} + NUM_W'(M / 2);
		for (int i = 0; i < 3; i++) begin
			norm_prod[i] = (NUM_W + RECIP_W)'(norm_num[i])
				* (NUM_W + RECIP_W)'(RECIP_N[RECIP_W-1:0]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bri_res[i] = sat16(rnd12(40'($signed({1'b0, norm_s1[i]})) * 40'(k_bri)));
			con_res[i] = sat16(rnd12((40'(ch_s2[i]) - 40'sd2048) * 40'(k_con))
				+ 40'sd2048);
			sat_res[i] = sat16(40'(gray_s4)
				+ rnd12((40'(ch_s4[i]) - 40'(gray_s4)) * 40'(k_sat)));
			c8_res[i]  = 8'((21'(clamp01(ch_s5[i])) * 21'd255 + 21'd2048) >> 12);
		end
		luma_sum = 40'(LUMA_R) * 40'(ch_s3[0]) + 40'(LUMA_G) * 40'(ch_s3[1])
			+ 40'(LUMA_B) * 40'(ch_s3[2]);
	end

	always_comb begin
		hi_c = c8_s6[0];
		lo_c = c8_s6[0];
		for (int i = 1; i < 3; i++) begin
			if (c8_s6[i] > hi_c) begin
				hi_c = c8_s6[i];
			end
			if (c8_s6[i] < lo_c) begin
				lo_c = c8_s6[i];
			end
		end
		d_c = hi_c - lo_c;
		if (c8_s6[0] == hi_c) begin
			n_c = $signed({4'd0, c8_s6[1]}) - $signed({4'd0, c8_s6[2]});
		end else if (c8_s6[1] == hi_c) begin
			n_c = $signed({3'd0, d_c, 1'b0}) + $signed({4'd0, c8_s6[2]})
				- $signed({4'd0, c8_s6[0]});
		end else begin
			n_c = $signed({2'd0, d_c, 2'b0}) + $signed({4'd0, c8_s6[0]})
				- $signed({4'd0, c8_s6[1]});
		end
		absn_c = n_s7[11] ? 11'(-n_s7) : n_s7[10:0];
	end

	always_comb begin
		sprod_c = 49'(snum_s8) * 49'(rh_s8);
		hprod_c = 55'(hnum_s8) * 55'(r6_s8);
		if (dz_s9) begin
			hq_c = 12'd0;
		end else if (neg_s9 && (hmag_s9 != 13'd0)) begin
			hq_c = 12'(13'd4096 - hmag_s9);
		end else begin
			hq_c = hmag_s9[11:0];
		end
		hsum_c  = hq_c + hue_q[11:0];
		h6_c    = 15'(hsum_c) * 15'd6;
		fcomp_c = 13'd4096 - 13'(h6_c[11:0]);
		xprod_c = 21'(v_s9) * 21'(13'd4096 - s_s9) + 21'd2048;
		yprod_c = 33'(v_s10) * 33'(25'h1000000 - sf_s10) + 33'h0800000;
		zprod_c = 33'(v_s10) * 33'(25'h1000000 - sfc_s10) + 33'h0800000;
	end

	always_comb begin
		case (sector_s11)
			3'd0: begin
				map_c[0] = v_s11; map_c[1] = z_s11; map_c[2] = x_s11;
			end
			3'd1: begin
				map_c[0] = y_s11; map_c[1] = v_s11; map_c[2] = x_s11;
			end
			3'd2: begin
				map_c[0] = x_s11; map_c[1] = v_s11; map_c[2] = z_s11;
			end
			3'd3: begin
				map_c[0] = x_s11; map_c[1] = y_s11; map_c[2] = v_s11;
			end
			3'd4: begin
				map_c[0] = z_s11; map_c[1] = x_s11; map_c[2] = v_s11;
			end
			default: begin
				map_c[0] = v_s11; map_c[1] = x_s11; map_c[2] = y_s11;
			end
		endcase
		if (dz_s11) begin
			for (int i = 0; i < 3; i++) begin
				map_c[i] = v_s11;
			end
		end
		for (int i = 0; i < 3; i++) begin
			hue_res[i] = hue_on ? $signed({3'd0, back_tbl[map_c[i]]}) : ch_s11[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tt_res[i] = ch_s12[i];
		end
		if (tmp_on) begin
			tt_res[0] = sat16(40'(tt_res[0]) + t_tmp);
			tt_res[2] = sat16(40'(tt_res[2]) - t_tmp);
		end
		if (tnt_pos) begin
			tt_res[0] = sat16(40'(tt_res[0]) + t_tnt_rb);
			tt_res[2] = sat16(40'(tt_res[2]) + t_tnt_rb);
			tt_res[1] = sat16(40'(tt_res[1]) - t_tnt_g);
		end else if (tnt_neg) begin
			tt_res[1] = sat16(40'(tt_res[1]) - t_tnt_neg);
		end
		for (int i = 0; i < 3; i++) begin
			out_prod[i] = (CB + 13)'(clamp01(ch_s13[i])) * (CB + 13)'(M)
				+ (CB + 13)'(2048);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s1  <= alpha_in;
			alpha_s2  <= alpha_s1;
			alpha_s3  <= alpha_s2;
			alpha_s4  <= alpha_s3;
			alpha_s5  <= alpha_s4;
			alpha_s6  <= alpha_s5;
			alpha_s7  <= alpha_s6;
			alpha_s8  <= alpha_s7;
			alpha_s9  <= alpha_s8;
			alpha_s10 <= alpha_s9;
			alpha_s11 <= alpha_s10;
			alpha_s12 <= alpha_s11;
			alpha_s13 <= alpha_s12;
			alpha_s14 <= alpha_s13;
			for (int i = 0; i < 3; i++) begin
				norm_s1[i] <= norm_prod[i][NSH+12:NSH];
				ch_s2[i]   <= bri_res[i];
				ch_s3[i]   <= con_res[i];
				ch_s4[i]   <= ch_s3[i];
				ch_s5[i]   <= sat_res[i];
				ch_s6[i]   <= ch_s5[i];
				c8_s6[i]   <= c8_res[i];
				ch_s7[i]   <= ch_s6[i];
				ch_s8[i]   <= ch_s7[i];
				ch_s9[i]   <= ch_s8[i];
				ch_s10[i]  <= ch_s9[i];
				ch_s11[i]  <= ch_s10[i];
				ch_s12[i]  <= hue_res[i];
				ch_s13[i]  <= tt_res[i];
				col_s14[i] <= out_prod[i][CB+11:12];
			end
			gray_s4    <= sat16(rnd12(luma_sum));
			hi_s7      <= hi_c;
			d_s7       <= d_c;
			n_s7       <= n_c;
			hi_s8      <= hi_s7;
			dz_s8      <= d_s7 == 8'd0;
			neg_s8     <= n_s7[11];
			snum_s8    <= {d_s7, 12'd0} + 20'(hi_s7 >> 1);
			hnum_s8    <= {absn_c, 12'd0} + 23'(10'(d_s7) * 10'd3);
			rh_s8      <= recip_hi_tbl[hi_s7];
			r6_s8      <= recip6_tbl[d_s7];
			v_s9       <= hi_s8;
			dz_s9      <= dz_s8;
			neg_s9     <= neg_s8;
			s_s9       <= sprod_c[40:28];
			hmag_s9    <= hprod_c[46:34];
			v_s10      <= v_s9;
			x_s10      <= xprod_c[19:12];
			dz_s10     <= dz_s9;
			sector_s10 <= h6_c[14:12];
			sf_s10     <= 25'(s_s9) * 25'(h6_c[11:0]);
			sfc_s10    <= 25'(s_s9) * 25'(fcomp_c);
			v_s11      <= v_s10;
			x_s11      <= x_s10;
			y_s11      <= yprod_c[31:24];
			z_s11      <= zprod_c[31:24];
			dz_s11     <= dz_s10;
			sector_s11 <= sector_s10;
		end
	end

	assign red_out   = col_s14[0];
	assign green_out = col_s14[1];
	assign blue_out  = col_s14[2];
	assign alpha_out = alpha_s14;

`include "pixel_color_grade_assert.svh"

	`PCG_ASSERT_NEXT(a_take_fills_first, pix_valid && !pix_stall, valid_s1)
	`PCG_ASSERT_NOW(a_max_not_below_span, valid_s7, hi_s7 >= d_s7)
	`PCG_ASSERT_NOW(a_sat_zero_on_grey, valid_s9, (s_s9 == 13'd0) == dz_s9)
	`PCG_ASSERT_NOW(a_sector_in_range, valid_s11, sector_s11 <= 3'd5)

endmodule
